### src/prls_pkg.sv
// Shared types, opcodes and default sizes for the priority ready-list scheduler.
package prls_pkg;

    localparam int NUM_PRIO_DEF  = 32;
    localparam int NUM_TASKS_DEF = 16;

    localparam int OPCODE_W    = 3;
    localparam int TASK_ID_W   = 4;
    localparam int TASK_PRIO_W = 5;

    localparam logic [OPCODE_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_YIELD    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_START    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SCHEDULE = 3'd4;

    typedef struct packed {
        logic switch_request;
        logic status;
    } op_res_t;

    typedef struct packed {
        logic                 valid;
        logic [TASK_ID_W-1:0] task_id;
    } summ_t;

endpackage

### src/priority_ready_list_scheduler.sv
// Top level of the priority ready-list scheduler: handshakes, pipeline and result register.
//
// The block keeps one doubly linked ready list per priority, priority 0 being
// the most urgent, and performs one operation per input item: insert, remove,
// yield, start or schedule, chosen by s_opcode. Each item yields exactly one
// result item carrying the switch request, the head of the most urgent
// nonempty list after the operation, whether any task is ready, and a status.
// Both channels use valid and ready. An item is held in an input register,
// its operation is applied to the list state as it enters the middle stage,
// and the result register is then loaded from that stage and the list
// lookup. One item is accepted per cycle while the result side keeps up;
// the operation stage and the list lookup that feeds the result register
// set that figure. When the receiver stalls, the result register holds its
// item and the stages behind it fill and then hold, with s_ready falling
// once all three are occupied. Reset empties every list, clears the running
// task and sets the running priority to 0.
module priority_ready_list_scheduler #(
    parameter int NUM_PRIO  = prls_pkg::NUM_PRIO_DEF,
    parameter int NUM_TASKS = prls_pkg::NUM_TASKS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [prls_pkg::OPCODE_W-1:0]      s_opcode,
    input  logic [prls_pkg::TASK_ID_W-1:0]     s_task_id,
    input  logic [prls_pkg::TASK_PRIO_W-1:0]   s_task_prio,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_switch_request,
    output logic [prls_pkg::TASK_ID_W-1:0]     m_next_task,
    output logic                               m_next_valid,
    output logic                               m_status
);

    logic                              v1_reg;
    logic                              v2_reg;
    logic                              m_valid_reg;
    logic [prls_pkg::OPCODE_W-1:0]     op_reg;
    logic [prls_pkg::TASK_ID_W-1:0]    tid_reg;
    logic [prls_pkg::TASK_PRIO_W-1:0]  tprio_reg;
    prls_pkg::op_res_t                 mid_res_reg;
    logic                              m_switch_request_reg;
    logic [prls_pkg::TASK_ID_W-1:0]    m_next_task_reg;
    logic                              m_next_valid_reg;
    logic                              m_status_reg;

    logic              accept;
    logic              adv2;
    logic              exec;
    prls_pkg::op_res_t res;
    prls_pkg::summ_t   summ;

    // The operation stage may only commit when the middle stage is empty or
    // moves on in the same cycle, since its result is read from the state it leaves.
    assign adv2    = v2_reg && (!m_valid_reg || m_ready);
    assign exec    = v1_reg && (!v2_reg || adv2);
    assign s_ready = !v1_reg || exec;
    assign accept  = s_valid && s_ready;

    prls_core #(
        .NUM_PRIO  (NUM_PRIO),
        .NUM_TASKS (NUM_TASKS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .exec      (exec),
        .opcode    (op_reg),
        .task_id   (tid_reg),
        .task_prio (tprio_reg),
        .res       (res),
        .summ      (summ)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (exec) begin
                v1_reg <= 1'b0;
            end
            if (exec) begin
                v2_reg <= 1'b1;
            end else if (adv2) begin
                v2_reg <= 1'b0;
            end
            if (adv2) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_opcode;
            tid_reg   <= s_task_id;
            tprio_reg <= s_task_prio;
        end
        if (exec) begin
            mid_res_reg <= res;
        end
        if (adv2) begin
            m_switch_request_reg <= mid_res_reg.switch_request;
            m_status_reg         <= mid_res_reg.status;
            m_next_task_reg      <= summ.task_id;
            m_next_valid_reg     <= summ.valid;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_switch_request = m_switch_request_reg;
    assign m_next_task      = m_next_task_reg;
    assign m_next_valid     = m_next_valid_reg;
    assign m_status         = m_status_reg;

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && m_valid_reg && !m_ready) |-> !exec)
        else $error("List state updated while the middle stage was held.");

    a_exec_fills_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> v2_reg)
        else $error("Executed item did not reach the middle stage.");

    a_switch_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_switch_request_reg) |-> !m_status_reg)
        else $error("Switch requested by an ignored operation.");

    a_empty_task: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_next_valid_reg) |-> (m_next_task_reg == '0))
        else $error("Next task not zero while no task is ready.");

endmodule

### src/prls_prio_enc.sv
// Priority encoder that finds the lowest set bit of the ready mask.
module prls_prio_enc #(
    parameter int WIDTH = prls_pkg::NUM_PRIO_DEF
) (
    input  logic [WIDTH-1:0]         req,
    output logic                     any,
    output logic [$clog2(WIDTH)-1:0] idx
);

    localparam int PW = $clog2(WIDTH);

    always_comb begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (req[i]) begin
                idx = PW'(i);
            end
        end
    end

    assign any = |req;

endmodule

### src/prls_core.sv
// Ready-list state and the single-pass update logic for one scheduler operation.
module prls_core #(
    parameter int NUM_PRIO  = prls_pkg::NUM_PRIO_DEF,
    parameter int NUM_TASKS = prls_pkg::NUM_TASKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                exec,
    input  logic [prls_pkg::OPCODE_W-1:0]       opcode,
    input  logic [prls_pkg::TASK_ID_W-1:0]      task_id,
    input  logic [prls_pkg::TASK_PRIO_W-1:0]    task_prio,
    output prls_pkg::op_res_t                   res,
    output prls_pkg::summ_t                     summ
);

    localparam int PW  = $clog2(NUM_PRIO);
    localparam int TW  = $clog2(NUM_TASKS);
    localparam int LW  = TW + 1;
    localparam int CW  = $clog2(NUM_TASKS + 1);
    localparam int IDW = prls_pkg::TASK_ID_W;

    typedef logic [LW-1:0] link_t;

    localparam link_t NIL = {1'b1, {TW{1'b0}}};

    // A list is nonempty exactly when its ready bit is set, so the ready mask
    // also marks which head, tail and count entries hold meaningful values.
    logic [NUM_PRIO-1:0]  ready_mask_reg;
    logic [NUM_PRIO-1:0]  ready_mask_next;
    logic [TW-1:0]        head_reg  [NUM_PRIO];
    logic [TW-1:0]        tail_reg  [NUM_PRIO];
    logic [CW-1:0]        count_reg [NUM_PRIO];
    link_t                next_reg  [NUM_TASKS];
    link_t                prev_reg  [NUM_TASKS];
    logic [PW-1:0]        sprio_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] in_list_reg;
    logic                 run_valid_reg;
    logic [TW-1:0]        run_task_reg;
    logic [PW-1:0]        run_prio_reg;

    logic          any;
    logic [PW-1:0] hp;
    logic [TW-1:0] best_head;

    logic          is_ins, is_rem, is_yield, is_start, is_sched;
    logic          task_ok, prio_ok;
    logic [TW-1:0] t;
    logic [PW-1:0] pi;
    logic [PW-1:0] op_p;
    logic [TW-1:0] h, tl, nh, lk_addr;
    logic          ne;
    logic [CW-1:0] cnt;
    link_t         pr, nxl;
    logic          ins_tail, ins_head;
    logic          do_ins, do_rem, do_rot, do_sched, do_start;
    logic [TW-1:0] sched_head;
    logic          st;

    logic          na_en, nb_en, pa_en, pb_en;
    logic [TW-1:0] na_addr, nb_addr, pa_addr, pb_addr;
    link_t         na_data, nb_data, pa_data, pb_data;
    logic          hd_we, tl_we, cnt_we, mask_set, mask_clr, il_we, il_d;
    logic [TW-1:0] hd_d, tl_d;
    logic [CW-1:0] cnt_d;
    logic [NUM_PRIO-1:0] op_bit;

    prls_prio_enc #(
        .WIDTH (NUM_PRIO)
    ) u_enc (
        .req (ready_mask_reg),
        .any (any),
        .idx (hp)
    );

    assign best_head = head_reg[hp];

    assign is_ins   = (opcode == prls_pkg::OP_INSERT);
    assign is_rem   = (opcode == prls_pkg::OP_REMOVE);
    assign is_yield = (opcode == prls_pkg::OP_YIELD);
    assign is_start = (opcode == prls_pkg::OP_START);
    assign is_sched = (opcode == prls_pkg::OP_SCHEDULE);

    assign task_ok = (int'(task_id) < NUM_TASKS);
    assign prio_ok = (int'(task_prio) < NUM_PRIO);
    assign t       = TW'(task_id);
    assign pi      = PW'(task_prio);

    assign op_p = is_ins ? pi : (is_rem ? sprio_reg[t] : run_prio_reg);
    assign h    = head_reg[op_p];
    assign tl   = tail_reg[op_p];
    assign ne   = ready_mask_reg[op_p];
    assign cnt  = count_reg[op_p];

    assign pr      = prev_reg[t];
    assign lk_addr = is_yield ? h : t;
    assign nxl     = next_reg[lk_addr];
    assign nh      = nxl[TW-1:0];

    assign ins_tail = ne && (op_p == run_prio_reg);
    assign ins_head = ne && !ins_tail;

    assign do_ins     = is_ins && task_ok && prio_ok && !in_list_reg[t];
    assign do_rem     = is_rem && task_ok && in_list_reg[t];
    assign do_rot     = is_yield && run_valid_reg && ne && (h != tl);
    assign sched_head = (do_rot && (hp == run_prio_reg)) ? nh : best_head;
    assign do_sched   = (is_yield || is_sched) && run_valid_reg && any
                        && (sched_head != run_task_reg);
    assign do_start   = is_start && any;

    always_comb begin
        case (opcode)
            prls_pkg::OP_INSERT:   st = !do_ins;
            prls_pkg::OP_REMOVE:   st = !do_rem;
            prls_pkg::OP_YIELD:    st = !run_valid_reg;
            prls_pkg::OP_START:    st = !any;
            prls_pkg::OP_SCHEDULE: st = !run_valid_reg;
            default:               st = 1'b1;
        endcase
    end

    always_comb begin
        na_en    = 1'b0;
        nb_en    = 1'b0;
        pa_en    = 1'b0;
        pb_en    = 1'b0;
        na_addr  = t;
        nb_addr  = tl;
        pa_addr  = t;
        pb_addr  = h;
        na_data  = NIL;
        nb_data  = NIL;
        pa_data  = NIL;
        pb_data  = NIL;
        hd_we    = 1'b0;
        tl_we    = 1'b0;
        cnt_we   = 1'b0;
        hd_d     = t;
        tl_d     = t;
        cnt_d    = cnt;
        mask_set = 1'b0;
        mask_clr = 1'b0;
        il_we    = 1'b0;
        il_d     = 1'b0;
        if (do_ins) begin
            na_en    = 1'b1;
            na_addr  = t;
            na_data  = ins_head ? {1'b0, h} : NIL;
            pa_en    = 1'b1;
            pa_addr  = t;
            pa_data  = ins_tail ? {1'b0, tl} : NIL;
            if (ins_tail) begin
                nb_en   = 1'b1;
                nb_addr = tl;
                nb_data = {1'b0, t};
                tl_we   = 1'b1;
            end
            if (ins_head) begin
                pb_en   = 1'b1;
                pb_addr = h;
                pb_data = {1'b0, t};
                hd_we   = 1'b1;
            end
            if (!ne) begin
                hd_we = 1'b1;
                tl_we = 1'b1;
                cnt_d = CW'(1);
            end else begin
                cnt_d = cnt + CW'(1);
            end
            cnt_we   = 1'b1;
            mask_set = 1'b1;
            il_we    = 1'b1;
            il_d     = 1'b1;
        end else if (do_rem) begin
            if (pr[TW]) begin
                if (!nxl[TW]) begin
                    hd_we = 1'b1;
                    hd_d  = nh;
                end
            end else begin
                na_en   = 1'b1;
                na_addr = pr[TW-1:0];
                na_data = nxl;
            end
            if (nxl[TW]) begin
                if (!pr[TW]) begin
                    tl_we = 1'b1;
                    tl_d  = pr[TW-1:0];
                end
            end else begin
                pa_en   = 1'b1;
                pa_addr = nh;
                pa_data = pr;
            end
            if (pr[TW] && nxl[TW]) begin
                mask_clr = 1'b1;
            end else begin
                cnt_we = 1'b1;
                cnt_d  = (cnt != '0) ? cnt - CW'(1) : cnt;
            end
            il_we = 1'b1;
            il_d  = 1'b0;
        end else if (do_rot) begin
            pa_en   = 1'b1;
            pa_addr = nh;
            pa_data = NIL;
            hd_we   = 1'b1;
            hd_d    = nh;
            nb_en   = 1'b1;
            nb_addr = tl;
            nb_data = {1'b0, h};
            pb_en   = 1'b1;
            pb_addr = h;
            pb_data = {1'b0, tl};
            na_en   = 1'b1;
            na_addr = h;
            na_data = NIL;
            tl_we   = 1'b1;
            tl_d    = h;
        end
    end

    assign op_bit          = {{(NUM_PRIO-1){1'b0}}, 1'b1} << op_p;
    assign ready_mask_next = mask_set ? (ready_mask_reg | op_bit)
                           : mask_clr ? (ready_mask_reg & ~op_bit)
                           : ready_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_mask_reg <= '0;
            in_list_reg    <= '0;
            run_valid_reg  <= 1'b0;
            run_prio_reg   <= '0;
        end else if (exec) begin
            ready_mask_reg <= ready_mask_next;
            if (il_we) begin
                in_list_reg[t] <= il_d;
            end
            if (do_sched || do_start) begin
                run_valid_reg <= 1'b1;
                run_prio_reg  <= hp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            if (do_sched || do_start) begin
                run_task_reg <= sched_head;
            end
            if (do_ins) begin
                sprio_reg[t] <= pi;
            end
            if (hd_we) begin
                head_reg[op_p] <= hd_d;
            end
            if (tl_we) begin
                tail_reg[op_p] <= tl_d;
            end
            if (cnt_we) begin
                count_reg[op_p] <= cnt_d;
            end
            if (na_en) begin
                next_reg[na_addr] <= na_data;
            end
            if (nb_en) begin
                next_reg[nb_addr] <= nb_data;
            end
            if (pa_en) begin
                prev_reg[pa_addr] <= pa_data;
            end
            if (pb_en) begin
                prev_reg[pb_addr] <= pb_data;
            end
        end
    end

    assign res.switch_request = do_sched;
    assign res.status         = st;
    assign summ.valid         = any;
    assign summ.task_id       = any ? IDW'(best_head) : '0;

endmodule

### verif/tb_priority_ready_list_scheduler.sv
// Self-checking testbench for the priority ready-list scheduler, with a built-in list predictor.
module tb_priority_ready_list_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASKS = prls_pkg::NUM_TASKS_DEF;
    localparam int PRIOS = prls_pkg::NUM_PRIO_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int DIRECTED_ROWS = 25;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SQUEEZE_CYCLES = 80;

    localparam logic [prls_pkg::OPCODE_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [prls_pkg::OPCODE_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [prls_pkg::OPCODE_W-1:0] OP_UNUSED_HI  = 3'd7;

    localparam logic [4:0] NO_TASK = 5'h1F;

    typedef struct packed {
        logic                           sw;
        logic [prls_pkg::TASK_ID_W-1:0] nt;
        logic                           nv;
        logic                           st;
    } sched_outcome_t;

    typedef struct {
        logic [prls_pkg::OPCODE_W-1:0]    op;
        logic [prls_pkg::TASK_ID_W-1:0]   id;
        logic [prls_pkg::TASK_PRIO_W-1:0] prio;
        bit                               fixed;
        sched_outcome_t                   want;
    } dir_row_t;

    localparam sched_outcome_t IGNORED_EMPTY = {1'b0, 4'd0, 1'b0, 1'b1};
    localparam sched_outcome_t PREDICTED     = '0;

    logic                             aclk;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [prls_pkg::OPCODE_W-1:0]    s_opcode = '0;
    logic [prls_pkg::TASK_ID_W-1:0]   s_task_id = '0;
    logic [prls_pkg::TASK_PRIO_W-1:0] s_task_prio = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic                             m_switch_request;
    logic [prls_pkg::TASK_ID_W-1:0]   m_next_task;
    logic                             m_next_valid;
    logic                             m_status;

    // Predicted scheduler state.
    logic [4:0]  head_of [PRIOS];
    logic [4:0]  tail_of [PRIOS];
    logic [4:0]  fwd     [TASKS];
    logic [4:0]  back    [TASKS];
    logic [4:0]  prio_of [TASKS];
    bit          queued  [TASKS];
    logic [31:0] ready_bits;
    logic [4:0]  run_task;
    logic [4:0]  run_prio;

    sched_outcome_t outcomes_q[$];
    dir_row_t       directed_rows[DIRECTED_ROWS];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  op_count[8];
    int  switch_total = 0;
    int  ignored_total = 0;
    bit  steady = 1'b0;
    bit  squeeze_req = 1'b0;
    int  squeeze_left = 0;

    priority_ready_list_scheduler dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_task_id       (s_task_id),
        .s_task_prio     (s_task_prio),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_switch_request(m_switch_request),
        .m_next_task     (m_next_task),
        .m_next_valid    (m_next_valid),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit most_urgent(output logic [4:0] hp);
        hp = '0;
        for (int i = 0; i < PRIOS; i++) begin
            if (ready_bits[i]) begin
                hp = 5'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit reschedule();
        logic [4:0] hp;
        if (!most_urgent(hp))
            return 1'b0;
        if (head_of[hp] != run_task) begin
            run_task = head_of[hp];
            run_prio = hp;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sched_outcome_t apply_sched_op(
        logic [prls_pkg::OPCODE_W-1:0]    op,
        logic [prls_pkg::TASK_ID_W-1:0]   id,
        logic [prls_pkg::TASK_PRIO_W-1:0] prio);
        sched_outcome_t res;
        logic [4:0] t, h, tl, nx, pr, p, hp;
        res = '0;
        t = {1'b0, id};
        case (op)
            prls_pkg::OP_INSERT: begin
                if (queued[id]) begin
                    res.st = 1'b1;
                end else begin
                    h = head_of[prio];
                    queued[id] = 1'b1;
                    prio_of[id] = prio;
                    if (h == NO_TASK) begin
                        fwd[id] = NO_TASK;
                        back[id] = NO_TASK;
                        head_of[prio] = t;
                        tail_of[prio] = t;
                    end else if (prio == run_prio) begin
                        tl = tail_of[prio];
                        fwd[id] = NO_TASK;
                        back[id] = tl;
                        fwd[tl[3:0]] = t;
                        tail_of[prio] = t;
                    end else begin
                        fwd[id] = h;
                        back[id] = NO_TASK;
                        back[h[3:0]] = t;
                        head_of[prio] = t;
                    end
                    ready_bits[prio] = 1'b1;
                end
            end
            prls_pkg::OP_REMOVE: begin
                if (!queued[id]) begin
                    res.st = 1'b1;
                end else begin
                    p = prio_of[id];
                    pr = back[id];
                    nx = fwd[id];
                    if (pr == NO_TASK) head_of[p] = nx;
                    else fwd[pr[3:0]] = nx;
                    if (nx == NO_TASK) tail_of[p] = pr;
                    else back[nx[3:0]] = pr;
                    if (head_of[p] == NO_TASK)
                        ready_bits[p] = 1'b0;
                    fwd[id] = NO_TASK;
                    back[id] = NO_TASK;
                    queued[id] = 1'b0;
                end
            end
            prls_pkg::OP_YIELD: begin
                if (run_task == NO_TASK) begin
                    res.st = 1'b1;
                end else begin
                    h = head_of[run_prio];
                    tl = tail_of[run_prio];
                    if (h != NO_TASK && h != tl) begin
                        nx = fwd[h[3:0]];
                        back[nx[3:0]] = NO_TASK;
                        head_of[run_prio] = nx;
                        fwd[tl[3:0]] = h;
                        back[h[3:0]] = tl;
                        fwd[h[3:0]] = NO_TASK;
                        tail_of[run_prio] = h;
                    end
                    res.sw = reschedule();
                end
            end
            prls_pkg::OP_START: begin
                if (!most_urgent(hp)) begin
                    res.st = 1'b1;
                end else begin
                    run_prio = hp;
                    run_task = head_of[hp];
                end
            end
            prls_pkg::OP_SCHEDULE: begin
                if (run_task == NO_TASK) res.st = 1'b1;
                else res.sw = reschedule();
            end
            default: res.st = 1'b1;
        endcase
        if (most_urgent(hp)) begin
            res.nt = head_of[hp][3:0];
            res.nv = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [prls_pkg::TASK_ID_W-1:0] pick_task(bit want_queued);
        int pool[$];
        for (int i = 0; i < TASKS; i++)
            if (queued[i] == want_queued) pool.push_back(i);
        if (pool.size() == 0 || $urandom_range(9) == 0)
            return prls_pkg::TASK_ID_W'($urandom_range(TASKS - 1));
        return prls_pkg::TASK_ID_W'(pool[$urandom_range(pool.size() - 1)]);
    endfunction

    task automatic offer_item(logic [prls_pkg::OPCODE_W-1:0] op,
                              logic [prls_pkg::TASK_ID_W-1:0] id,
                              logic [prls_pkg::TASK_PRIO_W-1:0] prio,
                              bit fixed, sched_outcome_t want);
        sched_outcome_t predicted;
        while (!steady && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_task_id <= id;
        s_task_prio <= prio;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_sched_op(op, id, prio);
        outcomes_q.push_back(fixed ? want : predicted);
        op_count[op]++;
        switch_total += predicted.sw;
        ignored_total += predicted.st;
    endtask

    always @(posedge aclk) begin
        if (squeeze_req) begin
            squeeze_left = SQUEEZE_CYCLES;
            squeeze_req = 1'b0;
        end
        if (squeeze_left > 0) begin
            squeeze_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge aclk) begin
        sched_outcome_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (outcomes_q.size() == 0) begin
                $error("result item arrived with nothing expected");
                fail_count++;
            end else begin
                exp_res = outcomes_q.pop_front();
                if (m_switch_request !== exp_res.sw) begin
                    $error("switch_request: expected %0d, actual %0d",
                           exp_res.sw, m_switch_request);
                    fail_count++;
                end
                if (m_next_task !== exp_res.nt) begin
                    $error("next_task: expected %0d, actual %0d", exp_res.nt, m_next_task);
                    fail_count++;
                end
                if (m_next_valid !== exp_res.nv) begin
                    $error("next_valid: expected %0d, actual %0d", exp_res.nv, m_next_valid);
                    fail_count++;
                end
                if (m_status !== exp_res.st) begin
                    $error("status: expected %0d, actual %0d", exp_res.st, m_status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int r;
        logic [prls_pkg::OPCODE_W-1:0]    op;
        logic [prls_pkg::TASK_ID_W-1:0]   id;
        logic [prls_pkg::TASK_PRIO_W-1:0] prio;

        for (int i = 0; i < PRIOS; i++) begin
            head_of[i] = NO_TASK;
            tail_of[i] = NO_TASK;
        end
        for (int i = 0; i < TASKS; i++) begin
            fwd[i] = NO_TASK;
            back[i] = NO_TASK;
            prio_of[i] = '0;
            queued[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++) op_count[i] = 0;
        ready_bits = '0;
        run_task = NO_TASK;
        run_prio = '0;

        directed_rows = '{
            '{prls_pkg::OP_SCHEDULE, 4'd0,  5'd0,  1'b1, IGNORED_EMPTY},
            '{prls_pkg::OP_YIELD,    4'd0,  5'd0,  1'b1, IGNORED_EMPTY},
            '{prls_pkg::OP_START,    4'd0,  5'd0,  1'b1, IGNORED_EMPTY},
            '{prls_pkg::OP_REMOVE,   4'd3,  5'd0,  1'b1, IGNORED_EMPTY},
            '{OP_UNUSED_LO,          4'd15, 5'd31, 1'b1, IGNORED_EMPTY},
            '{OP_UNUSED_MID,         4'd5,  5'd10, 1'b1, IGNORED_EMPTY},
            '{OP_UNUSED_HI,          4'd15, 5'd31, 1'b1, IGNORED_EMPTY},
            '{prls_pkg::OP_INSERT,   4'd15, 5'd31, 1'b1, {1'b0, 4'd15, 1'b1, 1'b0}},
            '{prls_pkg::OP_INSERT,   4'd15, 5'd31, 1'b1, {1'b0, 4'd15, 1'b1, 1'b1}},
            '{prls_pkg::OP_INSERT,   4'd0,  5'd0,  1'b1, {1'b0, 4'd0,  1'b1, 1'b0}},
            '{prls_pkg::OP_INSERT,   4'd1,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_INSERT,   4'd2,  5'd5,  1'b0, PREDICTED},
            '{prls_pkg::OP_INSERT,   4'd3,  5'd5,  1'b0, PREDICTED},
            '{prls_pkg::OP_START,    4'd0,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_SCHEDULE, 4'd0,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_YIELD,    4'd0,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_INSERT,   4'd4,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_REMOVE,   4'd1,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_SCHEDULE, 4'd0,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_REMOVE,   4'd0,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_REMOVE,   4'd4,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_YIELD,    4'd0,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_YIELD,    4'd0,  5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_REMOVE,   4'd15, 5'd0,  1'b0, PREDICTED},
            '{prls_pkg::OP_SCHEDULE, 4'd15, 5'd31, 1'b0, PREDICTED}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].id, directed_rows[i].prio,
                       directed_rows[i].fixed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 100 && n < 200);
            if (n == 350) squeeze_req = 1'b1;
            r = $urandom_range(99);
            id = prls_pkg::TASK_ID_W'($urandom_range(TASKS - 1));
            prio = prls_pkg::TASK_PRIO_W'($urandom_range(PRIOS - 1));
            if (r < 35) begin
                op = prls_pkg::OP_INSERT;
                id = pick_task(1'b0);
                r = $urandom_range(99);
                if (r < 55) prio = prls_pkg::TASK_PRIO_W'($urandom_range(3));
                else if (r < 70) prio = run_prio;
                else if (r < 80) prio = prls_pkg::TASK_PRIO_W'(PRIOS - 1);
            end else if (r < 58) begin
                op = prls_pkg::OP_REMOVE;
                id = pick_task(1'b1);
            end else if (r < 70) begin
                op = prls_pkg::OP_YIELD;
            end else if (r < 78) begin
                op = prls_pkg::OP_START;
            end else if (r < 94) begin
                op = prls_pkg::OP_SCHEDULE;
            end else begin
                op = prls_pkg::OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end
            offer_item(op, id, prio, 1'b0, PREDICTED);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (outcomes_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d items: %0d inserts, %0d removes, %0d yields, %0d starts, %0d schedules",
                 DIRECTED_ROWS + RANDOM_ITEMS,
                 op_count[prls_pkg::OP_INSERT], op_count[prls_pkg::OP_REMOVE],
                 op_count[prls_pkg::OP_YIELD], op_count[prls_pkg::OP_START],
                 op_count[prls_pkg::OP_SCHEDULE]);
        $display("%0d unused opcodes, %0d switch requests, %0d ignored operations",
                 op_count[OP_UNUSED_LO] + op_count[OP_UNUSED_MID] + op_count[OP_UNUSED_HI],
                 switch_total, ignored_total);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
